### rtl/core/rgb_led_spi_frame_encoder_macros.svh
// assertion macros used by the frame encoder rtl
`ifndef RGB_LED_SPI_FRAME_ENCODER_MACROS_SVH
`define RGB_LED_SPI_FRAME_ENCODER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RLSFE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent checked in the cycle after the antecedent
`define RLSFE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/rlsfe_pkg.sv
// types and constants of the rgb led frame encoder
package rlsfe_pkg;

  localparam int CountW     = 10;
  localparam int ShiftW     = 5;
  localparam int ByteW      = 8;
  localparam int ColorW     = 32;
  localparam int FactorW    = 17;
  localparam int GammaDepth = 256;
  localparam int GammaAddrW = 8;
  localparam int LaneCount  = 3;
  localparam int StartCntW  = 2;
  localparam int StartBytes = 4;

  localparam logic [ByteW-1:0]     ByteStart = 8'h00;
  localparam logic [ByteW-1:0]     ByteMark  = 8'hFF;
  localparam logic [StartCntW-1:0] StartLast = StartCntW'(StartBytes - 1);

  typedef enum logic [2:0] {
    REG_LED_COUNT,
    REG_GLOBAL_BRIGHTNESS,
    REG_INVERT_OUTPUT,
    REG_RED_SHIFT,
    REG_GREEN_SHIFT,
    REG_BLUE_SHIFT
  } reg_index_t;

  typedef enum logic {
    CMD_PIXEL,
    CMD_GAMMA
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [ColorW-1:0] color_word;
    logic [ByteW-1:0]  pixel_brightness;
    logic [ByteW-1:0]  gamma_index;
    logic [ByteW-1:0]  gamma_value;
  } in_t;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             run_last;
    logic             frame_last;
  } out_t;

  typedef struct packed {
    logic go;
    logic skip_start;
    logic frame_end;
    logic chan_ready;
  } rlsfe_ctrl_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_START,
    M_HEAD,
    M_RED,
    M_GREEN,
    M_BLUE,
    M_END
  } merge_state_t;

endpackage

### rtl/core/rlsfe_lane.sv
// one color channel lane: byte select, brightness scale and gamma lookup
module rlsfe_lane (
  input  logic                                clk,
  input  logic [rlsfe_pkg::ColorW-1:0]        color,
  input  logic [rlsfe_pkg::ShiftW-1:0]        shift,
  input  logic [rlsfe_pkg::FactorW-1:0]       factor,
  input  logic                                scale_en,
  input  logic                                lookup_en,
  input  logic                                wr_en,
  input  logic [rlsfe_pkg::GammaAddrW-1:0]    wr_addr,
  input  logic [rlsfe_pkg::ByteW-1:0]         wr_data,
  input  logic [rlsfe_pkg::GammaDepth-1:0]    written,
  output logic [rlsfe_pkg::ByteW-1:0]         gamma_out
);
  import rlsfe_pkg::*;

  localparam int ProdW = FactorW + ByteW;

  logic [ColorW-1:0]     shifted;
  logic [ByteW-1:0]      chan_byte;
  logic [ProdW-1:0]      prod;
  logic [GammaAddrW-1:0] idx;
  logic [ByteW-1:0]      mem [GammaDepth];
  logic [ByteW-1:0]      rd_data;
  logic                  rd_written;

  assign shifted   = color >> shift;
  assign chan_byte = shifted[ByteW-1:0];
  assign prod      = ProdW'(chan_byte) * ProdW'(factor);

  always_ff @(posedge clk) begin
    if (scale_en) begin
      idx <= prod[16 +: GammaAddrW];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (lookup_en) begin
      rd_data    <= mem[idx];
      rd_written <= written[idx];
    end
  end

  // entries never loaded read as identity
  assign gamma_out = rd_written ? rd_data : idx;

endmodule

### rtl/core/rlsfe_merge.sv
// merging stage: orders start, led and end bytes into the output register
module rlsfe_merge #(
  parameter int END_W = 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rlsfe_pkg::rlsfe_ctrl_t       ctrl,
  input  logic [END_W-1:0]             ends,
  input  logic                         invert,
  input  logic [rlsfe_pkg::ByteW-1:0]  red,
  input  logic [rlsfe_pkg::ByteW-1:0]  green,
  input  logic [rlsfe_pkg::ByteW-1:0]  blue,
  output logic                         busy,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rlsfe_pkg::out_t              out_data
);
  import rlsfe_pkg::*;

  merge_state_t          state, state_next;
  logic [StartCntW-1:0]  start_cnt;
  logic [END_W-1:0]      end_cnt;
  logic                  frame_end_q;
  logic                  load_ok;
  logic                  emit;
  logic [ByteW-1:0]      raw_byte;
  logic                  run_last;
  logic                  frame_last;

  assign load_ok = !out_valid || !out_stall;
  assign busy    = (state != M_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      M_IDLE: begin
        if (ctrl.go) begin
          state_next = ctrl.skip_start ? M_HEAD : M_START;
        end
      end
      M_START: begin
        if (load_ok && start_cnt == StartLast) begin
          state_next = M_HEAD;
        end
      end
      M_HEAD: begin
        if (load_ok) begin
          state_next = M_RED;
        end
      end
      M_RED: begin
        if (load_ok && ctrl.chan_ready) begin
          state_next = M_GREEN;
        end
      end
      M_GREEN: begin
        if (load_ok && ctrl.chan_ready) begin
          state_next = M_BLUE;
        end
      end
      M_BLUE: begin
        if (load_ok && ctrl.chan_ready) begin
          state_next = frame_end_q ? M_END : M_IDLE;
        end
      end
      M_END: begin
        if (load_ok && end_cnt == END_W'(1)) begin
          state_next = M_IDLE;
        end
      end
      default: state_next = M_IDLE;
    endcase
  end

  always_comb begin
    emit       = 1'b0;
    raw_byte   = ByteMark;
    run_last   = 1'b0;
    frame_last = 1'b0;
    case (state)
      M_START: begin
        emit     = load_ok;
        raw_byte = ByteStart;
      end
      M_HEAD: begin
        emit = load_ok;
      end
      M_RED: begin
        emit     = load_ok && ctrl.chan_ready;
        raw_byte = red;
      end
      M_GREEN: begin
        emit     = load_ok && ctrl.chan_ready;
        raw_byte = green;
      end
      M_BLUE: begin
        emit     = load_ok && ctrl.chan_ready;
        raw_byte = blue;
        run_last = !frame_end_q;
      end
      M_END: begin
        emit       = load_ok;
        run_last   = (end_cnt == END_W'(1));
        frame_last = (end_cnt == END_W'(1));
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= M_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == M_IDLE && ctrl.go) begin
      start_cnt   <= '0;
      end_cnt     <= ends;
      frame_end_q <= ctrl.frame_end;
    end else if (emit && state == M_START) begin
      start_cnt <= start_cnt + StartCntW'(1);
    end else if (emit && state == M_END) begin
      end_cnt <= end_cnt - END_W'(1);
    end
    if (emit) begin
      out_data.out_byte   <= raw_byte ^ {ByteW{invert}};
      out_data.run_last   <= run_last;
      out_data.frame_last <= frame_last;
    end
  end

endmodule

### rtl/core/rgb_led_spi_frame_encoder.sv
// Serial rgb led frame encoder. Each pixel transaction becomes the byte stream 0xFF, R, G, B,
// led by four 0x00 start bytes on the first led of a frame and followed by ceil(count/16)
// 0xFF end bytes after the last; a gamma transaction rewrites one gamma entry and yields
// nothing. Three channel lanes work side by side, each with its own copy of the gamma
// table, and a merging stage orders their bytes into the output register at one byte per
// cycle while the output does not stall and the lane bytes are ready. Ahead of the three
// color bytes a pixel passes the lane pipeline (brightness factor, scaling multiply,
// registered gamma read); start and end bytes lengthen it. Invert output flips every byte.
// The gamma table reads as identity after reset with no clearing pass.
`include "rgb_led_spi_frame_encoder_macros.svh"

module rgb_led_spi_frame_encoder #(
  parameter int MAX_LEDS = 512
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [4:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  rlsfe_pkg::in_t        in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output rlsfe_pkg::out_t       out_data
);
  import rlsfe_pkg::*;

  localparam int EndW = $clog2((MAX_LEDS + 15) / 16 + 1);
  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_LEDS);

  logic [CountW-1:0]     led_count;
  logic [ByteW-1:0]      global_brightness;
  logic                  invert_output;
  logic [ShiftW-1:0]     red_shift;
  logic [ShiftW-1:0]     green_shift;
  logic [ShiftW-1:0]     blue_shift;
  logic [CountW-1:0]     led_position;
  logic [GammaDepth-1:0] gamma_written;

  logic                  cfg_wr;
  reg_index_t            cfg_idx;
  logic                  accept;
  logic                  pix_acc;
  logic                  gam_acc;
  logic [CountW-1:0]     count_eff;
  logic [CountW-1:0]     pos_adv;
  logic                  frame_end;
  logic [CountW:0]       ends_sum;
  logic [EndW-1:0]       ends;
  logic [ByteW:0]        gb_p1;
  logic [ByteW:0]        pb_p1;
  logic [FactorW-1:0]    factor_prod;

  logic [ColorW-1:0]     color;
  logic [FactorW-1:0]    factor;
  logic                  st_scale;
  logic                  st_lookup;
  logic                  chan_ready;

  logic [ShiftW-1:0]     lane_shift [LaneCount];
  logic [ByteW-1:0]      lane_byte  [LaneCount];
  rlsfe_ctrl_t           ctrl;
  logic                  merge_busy;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_index_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_count         <= CountW'(1);
      global_brightness <= '0;
      invert_output     <= 1'b0;
      red_shift         <= ShiftW'(16);
      green_shift       <= ShiftW'(8);
      blue_shift        <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LED_COUNT:         led_count         <= pwdata[CountW-1:0];
        REG_GLOBAL_BRIGHTNESS: global_brightness <= pwdata[ByteW-1:0];
        REG_INVERT_OUTPUT:     invert_output     <= pwdata[0];
        REG_RED_SHIFT:         red_shift         <= pwdata[ShiftW-1:0];
        REG_GREEN_SHIFT:       green_shift       <= pwdata[ShiftW-1:0];
        REG_BLUE_SHIFT:        blue_shift        <= pwdata[ShiftW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LED_COUNT:         prdata = 32'(led_count);
      REG_GLOBAL_BRIGHTNESS: prdata = 32'(global_brightness);
      REG_INVERT_OUTPUT:     prdata = 32'(invert_output);
      REG_RED_SHIFT:         prdata = 32'(red_shift);
      REG_GREEN_SHIFT:       prdata = 32'(green_shift);
      REG_BLUE_SHIFT:        prdata = 32'(blue_shift);
      default:               prdata = '0;
    endcase
  end

  // input transaction
  assign in_stall = merge_busy;
  assign accept   = in_valid && !in_stall;
  assign pix_acc  = accept && (in_data.cmd == CMD_PIXEL);
  assign gam_acc  = accept && (in_data.cmd == CMD_GAMMA);

  // a count of zero acts as one, above the limit as the limit
  always_comb begin
    if (led_count == '0) begin
      count_eff = CountW'(1);
    end else if (led_count > MaxCount) begin
      count_eff = MaxCount;
    end else begin
      count_eff = led_count;
    end
  end

  assign pos_adv     = led_position + CountW'(1);
  assign frame_end   = (pos_adv >= count_eff);
  assign ends_sum    = {1'b0, count_eff} + (CountW + 1)'(15);
  assign ends        = EndW'(ends_sum >> 4);
  assign gb_p1       = {1'b0, global_brightness} + (ByteW + 1)'(1);
  assign pb_p1       = {1'b0, in_data.pixel_brightness} + (ByteW + 1)'(1);
  assign factor_prod = FactorW'(gb_p1) * FactorW'(pb_p1);

  always_ff @(posedge clk) begin
    if (rst) begin
      led_position  <= '0;
      gamma_written <= '0;
      st_scale      <= 1'b0;
      st_lookup     <= 1'b0;
      chan_ready    <= 1'b0;
    end else begin
      st_scale  <= pix_acc;
      st_lookup <= st_scale;
      if (pix_acc) begin
        led_position <= frame_end ? '0 : pos_adv;
        chan_ready   <= 1'b0;
      end else if (st_lookup) begin
        chan_ready <= 1'b1;
      end
      if (gam_acc) begin
        gamma_written[in_data.gamma_index] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      color  <= in_data.color_word;
      factor <= factor_prod;
    end
  end

  assign lane_shift[0] = red_shift;
  assign lane_shift[1] = green_shift;
  assign lane_shift[2] = blue_shift;

  for (genvar g = 0; g < LaneCount; g++) begin : g_lane
    rlsfe_lane u_lane (
      .clk       (clk),
      .color     (color),
      .shift     (lane_shift[g]),
      .factor    (factor),
      .scale_en  (st_scale),
      .lookup_en (st_lookup),
      .wr_en     (gam_acc),
      .wr_addr   (in_data.gamma_index),
      .wr_data   (in_data.gamma_value),
      .written   (gamma_written),
      .gamma_out (lane_byte[g])
    );
  end

  assign ctrl.go         = pix_acc;
  assign ctrl.skip_start = (led_position != '0);
  assign ctrl.frame_end  = frame_end;
  assign ctrl.chan_ready = chan_ready;

  rlsfe_merge #(
    .END_W (EndW)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .ends      (ends),
    .invert    (invert_output),
    .red       (lane_byte[0]),
    .green     (lane_byte[1]),
    .blue      (lane_byte[2]),
    .busy      (merge_busy),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  `RLSFE_ASSERT_NEXT(a_pixel_blocks_input, pix_acc, in_stall, "input open right after a pixel")
  `RLSFE_ASSERT_NOW(a_position_in_range, 1'b1, led_position < MaxCount, "led position past limit")
  `RLSFE_ASSERT_NEXT(a_gamma_marked, gam_acc,
                     gamma_written[$past(in_data.gamma_index)], "gamma entry not marked")
  `RLSFE_ASSERT_NOW(a_frame_last_ends_run, out_valid && out_data.frame_last,
                    out_data.run_last, "frame end without run end")

endmodule
